// ===== design/toq_pkg.sv =====
// ----------------------------------------------------------------------------
// toq_pkg
// Shared widths, status codes and controller/datapath command types for the
// time-ordered event queue.
// ----------------------------------------------------------------------------
package toq_pkg;

   localparam int TIME_W = 48;
   localparam int TYPE_W = 2;
   localparam int STAT_W = 2;
   localparam int ENT_W  = TIME_W + TYPE_W;

   localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STAT_W-1:0] ST_POPPED   = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

   localparam logic [2:0] PTR_HOLD = 3'd0;
   localparam logic [2:0] PTR_TAIL = 3'd1;
   localparam logic [2:0] PTR_HEAD = 3'd2;
   localparam logic [2:0] PTR_DEC  = 3'd3;
   localparam logic [2:0] PTR_INC  = 3'd4;

   localparam logic [1:0] RD_HEAD = 2'd0;
   localparam logic [1:0] RD_TAIL = 2'd1;
   localparam logic [1:0] RD_PREV = 2'd2;

   typedef struct packed {
      logic              load;
      logic [2:0]        ptr_op;
      logic [1:0]        rd_sel;
      logic              wr_shift;
      logic              wr_place;
      logic              pop;
      logic              res_load;
      logic [STAT_W-1:0] res_status;
   } toq_cmd_type;

   typedef struct packed {
      logic is_pop;
      logic empty;
      logic full;
      logic ge;
      logic last;
   } toq_stat_type;

endpackage

// ===== design/toq_if.sv =====
// ----------------------------------------------------------------------------
// toq_if
// Valid/ready channels for request and response words of the event queue.
// ----------------------------------------------------------------------------
interface toq_req_if;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic [toq_pkg::TIME_W-1:0]   event_time;
   logic [toq_pkg::TYPE_W-1:0]   event_kind;

   modport source (output valid, output command, output event_time, output event_kind,
                   input ready);
   modport sink   (input valid, input command, input event_time, input event_kind,
                   output ready);
endinterface

interface toq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [toq_pkg::STAT_W-1:0]   status;
   logic [toq_pkg::TIME_W-1:0]   out_time;
   logic [toq_pkg::TYPE_W-1:0]   out_type;

   modport source (output valid, output status, output out_time, output out_type,
                   input ready);
   modport sink   (input valid, input status, input out_time, input out_type,
                   output ready);
endinterface

// ===== design/toq_dpath.sv =====
// ----------------------------------------------------------------------------
// toq_dpath
// Entry memory kept as a sorted circular buffer, walk pointer, compare and
// response register.
// ----------------------------------------------------------------------------
module toq_dpath #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_command,
   input  logic [toq_pkg::TIME_W-1:0] req_event_time,
   input  logic [toq_pkg::TYPE_W-1:0] req_event_kind,
   input  toq_pkg::toq_cmd_type       cmd,
   output toq_pkg::toq_stat_type      stat,
   output logic [toq_pkg::STAT_W-1:0] rsp_status,
   output logic [toq_pkg::TIME_W-1:0] rsp_out_time,
   output logic [toq_pkg::TYPE_W-1:0] rsp_out_type
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

   logic [toq_pkg::ENT_W-1:0]  mem [QUEUE_DEPTH];

   logic                       cmd_ff;
   logic [toq_pkg::TIME_W-1:0] time_ff;
   logic [toq_pkg::TYPE_W-1:0] type_ff;
   logic [IDX_W-1:0]           head_ff, head_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [IDX_W-1:0]           ptr_ff, ptr_in;
   logic [CNT_W-1:0]           left_ff, left_in;
   logic [toq_pkg::ENT_W-1:0]  rd_ff;
   logic [toq_pkg::STAT_W-1:0] status_ff;
   logic [toq_pkg::TIME_W-1:0] otime_ff;
   logic [toq_pkg::TYPE_W-1:0] otype_ff;

   logic [toq_pkg::TIME_W-1:0] rd_time;
   logic [toq_pkg::TYPE_W-1:0] rd_typ;
   logic [IDX_W-1:0]           ptr_inc, ptr_dec, head_inc, tail;
   logic [SUM_W-1:0]           tail_sum;
   logic [IDX_W-1:0]           rd_addr, wr_addr;
   logic [toq_pkg::ENT_W-1:0]  wr_data;
   logic                       wr_en;
   logic                       res_popped;

   assign rd_time = rd_ff[toq_pkg::ENT_W-1:toq_pkg::TYPE_W];
   assign rd_typ  = rd_ff[toq_pkg::TYPE_W-1:0];

   assign ptr_inc  = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + IDX_W'(1);
   assign ptr_dec  = (ptr_ff == '0) ? LAST_IDX : ptr_ff - IDX_W'(1);
   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_W'(1);

   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff) - SUM_W'(1);
   assign tail     = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);

   assign stat.is_pop = cmd_ff;
   assign stat.empty  = (count_ff == '0);
   assign stat.full   = (count_ff == DEPTH_C);
   assign stat.ge     = (rd_time >= time_ff);
   assign stat.last   = (left_ff == CNT_W'(1));

   always_comb begin
      unique case (cmd.ptr_op)
         toq_pkg::PTR_TAIL: ptr_in = tail;
         toq_pkg::PTR_HEAD: ptr_in = head_ff;
         toq_pkg::PTR_DEC:  ptr_in = ptr_dec;
         toq_pkg::PTR_INC:  ptr_in = ptr_inc;
         default:           ptr_in = ptr_ff;
      endcase
      unique case (cmd.rd_sel)
         toq_pkg::RD_TAIL: rd_addr = tail;
         toq_pkg::RD_PREV: rd_addr = ptr_dec;
         default:          rd_addr = head_ff;
      endcase
      if (cmd.ptr_op == toq_pkg::PTR_TAIL) begin
         left_in = count_ff;
      end else if (cmd.ptr_op == toq_pkg::PTR_DEC) begin
         left_in = left_ff - CNT_W'(1);
      end else begin
         left_in = left_ff;
      end
      count_in = count_ff;
      head_in  = head_ff;
      if (cmd.wr_place) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
         head_in  = head_inc;
      end
   end

   assign wr_en      = cmd.wr_shift | cmd.wr_place;
   assign wr_addr    = cmd.wr_shift ? ptr_inc : ptr_ff;
   assign wr_data    = cmd.wr_shift ? rd_ff : {time_ff, type_ff};
   assign res_popped = (cmd.res_status == toq_pkg::ST_POPPED);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      left_ff <= left_in;
      if (cmd.load) begin
         cmd_ff  <= req_command;
         time_ff <= req_event_time;
         type_ff <= req_event_kind;
      end
      if (cmd.res_load) begin
         status_ff <= cmd.res_status;
         otime_ff  <= res_popped ? rd_time : '0;
         otype_ff  <= res_popped ? rd_typ : '0;
      end
   end

   assign rsp_status   = status_ff;
   assign rsp_out_time = otime_ff;
   assign rsp_out_type = otype_ff;

endmodule

// ===== design/toq_ctrl.sv =====
// ----------------------------------------------------------------------------
// toq_ctrl
// Sequencer for insert walk, pop and response handoff of the event queue.
// ----------------------------------------------------------------------------
module toq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  toq_pkg::toq_stat_type stat,
   output toq_pkg::toq_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DISP  = 3'd1;
   localparam logic [2:0] S_POP   = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_PLACE = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [toq_pkg::STAT_W-1:0] pend_ff, pend_in;
   logic                       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      pend_in    = pend_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.is_pop) begin
               if (stat.empty) begin
                  pend_in  = toq_pkg::ST_EMPTY;
                  state_in = S_DONE;
               end else begin
                  cmd.rd_sel = toq_pkg::RD_HEAD;
                  state_in   = S_POP;
               end
            end else if (stat.full) begin
               pend_in  = toq_pkg::ST_FULL;
               state_in = S_DONE;
            end else if (stat.empty) begin
               cmd.ptr_op = toq_pkg::PTR_HEAD;
               state_in   = S_PLACE;
            end else begin
               cmd.ptr_op = toq_pkg::PTR_TAIL;
               cmd.rd_sel = toq_pkg::RD_TAIL;
               state_in   = S_CMP;
            end
         end
         S_POP: begin
            cmd.rd_sel = toq_pkg::RD_HEAD;
            if (slot_free) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = toq_pkg::ST_POPPED;
               cmd.pop        = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_CMP: begin
            if (stat.ge) begin
               cmd.wr_shift = 1'b1;
               if (stat.last) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.ptr_op = toq_pkg::PTR_DEC;
                  cmd.rd_sel = toq_pkg::RD_PREV;
               end
            end else begin
               cmd.ptr_op = toq_pkg::PTR_INC;
               state_in   = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.wr_place = 1'b1;
            pend_in      = toq_pkg::ST_INSERTED;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = pend_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule

// ===== design/time_ordered_event_queue_top.sv =====
// Pop, rejected insert, pop on empty: DISP then POP or DONE loads the response; one word in flight.
// Insert: after DISP the walk reads entries from the tail, shifting up a slot each one whose
// time is >= the new time; PLACE then writes the new entry. A held response stalls POP or DONE.
// The insert walk moves one entry per cycle through the single write port of the entry memory.
// Reset (synchronous) empties the queue; entry memory is not cleared.
// ----------------------------------------------------------------------------
// time_ordered_event_queue_top
// Future-event list sorted by timestamp; insert and pop-earliest commands.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   toq_req_if.sink    req_ch,
   toq_rsp_if.source  rsp_ch
);

   toq_pkg::toq_cmd_type  cmd;
   toq_pkg::toq_stat_type stat;

   toq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   toq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_ch.command),
      .req_event_time (req_ch.event_time),
      .req_event_kind (req_ch.event_kind),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_status     (rsp_ch.status),
      .rsp_out_time   (rsp_ch.out_time),
      .rsp_out_type   (rsp_ch.out_type)
   );

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while another word is in flight");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status != toq_pkg::ST_POPPED))
         |-> (rsp_ch.out_time == '0 && rsp_ch.out_type == '0))
      else $error("non-pop response carries event data");

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_place |-> !stat.full)
      else $error("entry placed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !stat.empty)
      else $error("entry removed from empty queue");
`endif

endmodule
